[rtl/core/adc_timing_config_calculator_defines.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ADC_TIMING_CONFIG_CALCULATOR_DEFINES_SVH
`define ADC_TIMING_CONFIG_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ATCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ATCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/atcc_pkg.sv]
package atcc_pkg;

  localparam int DW    = 30;
  localparam int NSTEP = DW;
  localparam int NAVG  = 5;
  localparam int AW    = 5;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dq;
    logic [DW-1:0] dvs;
  } div_lane_t;

  typedef div_lane_t [NAVG-1:0] lane_vec_t;

  typedef struct packed {
    logic [DW-1:0] bus;
    logic [DW-1:0] adck;
    logic [4:0]    e;
    logic          fault;
    logic [2:0]    idx;
  } side_t;

  localparam logic [2:0] REG_MAX_CLK  = 3'd0;
  localparam logic [2:0] REG_MIN_TIME = 3'd1;
  localparam logic [2:0] REG_RES      = 3'd2;
  localparam logic [2:0] REG_CLK_SRC  = 3'd3;
  localparam logic [2:0] REG_CONV     = 3'd4;
  localparam logic [2:0] REG_REF      = 3'd5;
  localparam logic [2:0] REG_OVR      = 3'd6;
  localparam logic [2:0] REG_AVG      = 3'd7;

  localparam logic [DW-1:0] NS_PER_S = 30'd1000000000;
  localparam logic [4:0]    FALLBACK_E = 5'd3;
  localparam logic [5:0]    BASE_CYCLES = 6'd25;
  localparam logic [DW-1:0] SETUP_CYCLES = 30'd6;

  localparam logic [2:0] AVG_SHIFT [NAVG] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5};

  localparam logic [16:0] CFG_RES10   = 17'h00004;
  localparam logic [16:0] CFG_RES12   = 17'h00008;
  localparam logic [16:0] CFG_DIV2    = 17'h00020;
  localparam logic [16:0] CFG_DIV4    = 17'h00040;
  localparam logic [16:0] CFG_DIV8    = 17'h00060;
  localparam logic [16:0] CFG_DIV16   = 17'h00061;
  localparam logic [16:0] CFG_LP      = 17'h00080;
  localparam logic [16:0] CFG_HS      = 17'h00400;
  localparam logic [16:0] CFG_VALT    = 17'h00800;
  localparam logic [16:0] CFG_BANDGAP = 17'h01000;
  localparam logic [16:0] CFG_AVG8    = 17'h04000;
  localparam logic [16:0] CFG_AVG16   = 17'h08000;
  localparam logic [16:0] CFG_AVG32   = 17'h0C000;
  localparam logic [16:0] CFG_OVWR    = 17'h10000;
  localparam logic [7:0]  GC_AVGE     = 8'h20;

  function automatic logic [4:0] adder_cycles(input logic [2:0] i);
    logic [4:0] c;
    case (i)
      3'd0: c = 5'd3;
      3'd1: c = 5'd5;
      3'd2: c = 5'd7;
      3'd3: c = 5'd9;
      3'd4: c = 5'd13;
      3'd5: c = 5'd17;
      3'd6: c = 5'd21;
      default: c = 5'd25;
    endcase
    return c;
  endfunction

  function automatic logic [16:0] adder_bits(input logic [2:0] i);
    logic [16:0] b;
    case (i)
      3'd0: b = 17'h000;
      3'd1: b = 17'h100;
      3'd2: b = 17'h200;
      3'd3: b = 17'h300;
      3'd4: b = 17'h010;
      3'd5: b = 17'h110;
      3'd6: b = 17'h210;
      default: b = 17'h310;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/atcc_div_cell.sv]
module atcc_div_cell
  import atcc_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  div_lane_t lane_in,
  output div_lane_t lane_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {lane_in.rem, lane_in.dq[DW-1]};
  assign diff  = trial - {1'b0, lane_in.dvs};
  assign ge    = trial >= {1'b0, lane_in.dvs};

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      lane_out.dq  <= {lane_in.dq[DW-2:0], ge};
      lane_out.dvs <= lane_in.dvs;
    end
  end

endmodule

[rtl/core/atcc_div_chain.sv]
module atcc_div_chain
  import atcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  side_t     side_in,
  input  lane_vec_t lanes_in,
  output logic      valid_out,
  output side_t     side_out,
  output lane_vec_t lanes_out
);

  lane_vec_t        stage_q [NSTEP];
  side_t            side_q  [NSTEP];
  logic [NSTEP-1:0] vld;

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    for (genvar l = 0; l < NAVG; l++) begin : g_lane
      if (s == 0) begin : g_first
        atcc_div_cell u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (lanes_in[l]),
          .lane_out (stage_q[s][l])
        );
      end else begin : g_next
        atcc_div_cell u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (stage_q[s-1][l]),
          .lane_out (stage_q[s][l])
        );
      end
    end

    if (s == 0) begin : g_side_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_q[s] <= side_in;
        end
      end
    end else begin : g_side_next
      always_ff @(posedge clk) begin
        if (en) begin
          side_q[s] <= side_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTEP-2:0], valid_in};
    end
  end

  assign valid_out = vld[NSTEP-1];
  assign side_out  = side_q[NSTEP-1];
  assign lanes_out = stage_q[NSTEP-1];

endmodule

[rtl/core/adc_timing_config_calculator.sv]
// ADC timing calculator: each bus clock transaction yields one result with the
// divider exponent, long-sample adder index, CFG/GC words, five sample rates and
// a fault flag. A new transaction is taken every cycle unless the output stalls;
// results pass through four 30-cell restoring divider chains in a row
// (bus/max, 1e9/adck, min_time/period, then five rate divides side by side),
// one quotient bit per cell, plus three register stages (b0 and d0 between chains,
// then the output register). A stalled output holds the whole pipeline. Registers
// must be written over APB only while no transaction is in flight; the block does not enforce this.
`include "adc_timing_config_calculator_defines.svh"

module adc_timing_config_calculator
  import atcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // APB
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // [29:0] bus_clock_hz
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [4:0] divider_log2, [7:5] adder_index, [24:8] cfg_word, [32:25] gc_word,
  // [62:33] rate_avg1, [92:63] rate_avg4, [122:93] rate_avg8,
  // [152:123] rate_avg16, [182:153] rate_avg32
  output logic [183:0]  m_axis_tdata,
  output logic [0:0]    m_axis_tuser    // [0] fault
);

  logic [DW-1:0] max_adc_clock_hz;
  logic [19:0]   min_sample_time_ns;
  logic [1:0]    resolution_mode;
  logic [1:0]    clock_source;
  logic [1:0]    conversion_mode;
  logic [1:0]    reference_select;
  logic          overwrite_enable;
  logic [2:0]    average_select;

  logic          cfg_wr;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_adc_clock_hz   <= '0;
      min_sample_time_ns <= 20'd1000;
      resolution_mode    <= 2'd2;
      clock_source       <= 2'd0;
      conversion_mode    <= 2'd2;
      reference_select   <= 2'd0;
      overwrite_enable   <= 1'b1;
      average_select     <= 3'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_CLK:  max_adc_clock_hz   <= pwdata[DW-1:0];
        REG_MIN_TIME: min_sample_time_ns <= pwdata[19:0];
        REG_RES:      resolution_mode    <= pwdata[1:0];
        REG_CLK_SRC:  clock_source       <= pwdata[1:0];
        REG_CONV:     conversion_mode    <= pwdata[1:0];
        REG_REF:      reference_select   <= pwdata[1:0];
        REG_OVR:      overwrite_enable   <= pwdata[0];
        REG_AVG:      average_select     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_CLK:  prdata = {2'b0, max_adc_clock_hz};
      REG_MIN_TIME: prdata = {12'b0, min_sample_time_ns};
      REG_RES:      prdata = {30'b0, resolution_mode};
      REG_CLK_SRC:  prdata = {30'b0, clock_source};
      REG_CONV:     prdata = {30'b0, conversion_mode};
      REG_REF:      prdata = {30'b0, reference_select};
      REG_OVR:      prdata = {31'b0, overwrite_enable};
      REG_AVG:      prdata = {29'b0, average_select};
      default:      prdata = '0;
    endcase
  end

  // Advance everything unless the result register is stalled.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Divide bus clock by the maximum ADC clock.
  side_t     side_a_in, side_a_out;
  lane_vec_t lanes_a_in, lanes_a_out;
  logic      vld_a_out;

  always_comb begin
    side_a_in      = '0;
    side_a_in.bus  = s_axis_tdata[DW-1:0];
    lanes_a_in     = '0;
    lanes_a_in[0].dq  = s_axis_tdata[DW-1:0];
    lanes_a_in[0].dvs = (max_adc_clock_hz == '0) ? DW'(1) : max_adc_clock_hz;
  end

  atcc_div_chain u_chain_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s_axis_tvalid),
    .side_in   (side_a_in),
    .lanes_in  (lanes_a_in),
    .valid_out (vld_a_out),
    .side_out  (side_a_out),
    .lanes_out (lanes_a_out)
  );

  logic [DW:0] q_plus1;
  logic [4:0]  fls_e;
  logic [4:0]  e_a;
  logic [DW-1:0] adck_a;

  assign q_plus1 = {1'b0, lanes_a_out[0].dq} + (DW+1)'(1);

  always_comb begin
    fls_e = '0;
    for (int i = 0; i <= DW; i++) begin
      if (q_plus1[i]) begin
        fls_e = 5'(i + 1);
      end
    end
  end

  assign e_a    = (max_adc_clock_hz == '0) ? FALLBACK_E : fls_e;
  assign adck_a = side_a_out.bus >> e_a;

  side_t side_b0;
  logic  vld_b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b0 <= 1'b0;
    end else if (en) begin
      vld_b0 <= vld_a_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b0.bus   <= side_a_out.bus;
      side_b0.adck  <= adck_a;
      side_b0.e     <= e_a;
      side_b0.fault <= (adck_a == '0);
      side_b0.idx   <= '0;
    end
  end

  // Period in ns of the ADC clock.
  lane_vec_t lanes_b_in, lanes_b_out;
  side_t     side_b_out;
  logic      vld_b_out;

  always_comb begin
    lanes_b_in        = '0;
    lanes_b_in[0].dq  = NS_PER_S;
    lanes_b_in[0].dvs = side_b0.fault ? DW'(1) : side_b0.adck;
  end

  atcc_div_chain u_chain_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (vld_b0),
    .side_in   (side_b0),
    .lanes_in  (lanes_b_in),
    .valid_out (vld_b_out),
    .side_out  (side_b_out),
    .lanes_out (lanes_b_out)
  );

  // Divide the minimum sample time by the ADC clock period.
  lane_vec_t lanes_c_in, lanes_c_out;
  side_t     side_c_out;
  logic      vld_c_out;

  always_comb begin
    lanes_c_in        = '0;
    lanes_c_in[0].dq  = DW'(min_sample_time_ns);
    lanes_c_in[0].dvs = lanes_b_out[0].dq;
  end

  atcc_div_chain u_chain_c (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (vld_b_out),
    .side_in   (side_b_out),
    .lanes_in  (lanes_c_in),
    .valid_out (vld_c_out),
    .side_out  (side_c_out),
    .lanes_out (lanes_c_out)
  );

  logic [2:0] idx_c;
  logic [5:0] conv_cycles;

  // Pick the first adder whose cycle count exceeds the need; index 0 if none does or on a fault.
  always_comb begin
    idx_c = '0;
    for (int i = 7; i >= 0; i--) begin
      if (DW'(adder_cycles(3'(i))) > lanes_c_out[0].dq) begin
        idx_c = 3'(i);
      end
    end
    if (side_c_out.fault) begin
      idx_c = '0;
    end
  end

  assign conv_cycles = BASE_CYCLES + 6'(adder_cycles(idx_c));

  side_t     side_d0;
  lane_vec_t lanes_d0;
  logic      vld_d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d0 <= 1'b0;
    end else if (en) begin
      vld_d0 <= vld_c_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d0.bus   <= side_c_out.bus;
      side_d0.adck  <= side_c_out.adck;
      side_d0.e     <= side_c_out.e;
      side_d0.fault <= side_c_out.fault;
      side_d0.idx   <= idx_c;
      for (int l = 0; l < NAVG; l++) begin
        lanes_d0[l].rem <= '0;
        lanes_d0[l].dq  <= side_c_out.fault ? '0 : side_c_out.adck;
        lanes_d0[l].dvs <= (DW'(conv_cycles) << AVG_SHIFT[l]) + SETUP_CYCLES;
      end
    end
  end

  // Five sample rates side by side.
  lane_vec_t lanes_d_out;
  side_t     side_d_out;
  logic      vld_d_out;

  atcc_div_chain u_chain_d (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (vld_d0),
    .side_in   (side_d0),
    .lanes_in  (lanes_d0),
    .valid_out (vld_d_out),
    .side_out  (side_d_out),
    .lanes_out (lanes_d_out)
  );

  logic [16:0] cfg_next;
  logic [7:0]  gc_next;

  always_comb begin
    cfg_next = '0;
    gc_next  = '0;
    if (reference_select == 2'd1) begin
      cfg_next |= CFG_VALT;
    end else if (reference_select == 2'd2) begin
      cfg_next |= CFG_BANDGAP;
    end
    if (overwrite_enable) begin
      cfg_next |= CFG_OVWR;
    end
    if (resolution_mode == 2'd1) begin
      cfg_next |= CFG_RES10;
    end else if (resolution_mode == 2'd2) begin
      cfg_next |= CFG_RES12;
    end
    case (side_d_out.e)
      5'd1: cfg_next |= CFG_DIV2;
      5'd2: cfg_next |= CFG_DIV4;
      5'd3: cfg_next |= CFG_DIV8;
      5'd4: if (clock_source == 2'd0) begin
        cfg_next |= CFG_DIV16;
      end
      default: ;
    endcase
    cfg_next |= adder_bits(side_d_out.idx);
    case (average_select)
      3'd1: gc_next = GC_AVGE;
      3'd2: begin
        gc_next = GC_AVGE;
        cfg_next |= CFG_AVG8;
      end
      3'd3: begin
        gc_next = GC_AVGE;
        cfg_next |= CFG_AVG16;
      end
      3'd4: begin
        gc_next = GC_AVGE;
        cfg_next |= CFG_AVG32;
      end
      default: ;
    endcase
    if (conversion_mode == 2'd2) begin
      cfg_next |= CFG_LP;
    end
    if (conversion_mode == 2'd1) begin
      cfg_next |= CFG_HS;
    end
  end

  logic [4:0]    out_e;
  logic [2:0]    out_idx;
  logic [16:0]   out_cfg;
  logic [7:0]    out_gc;
  logic [DW-1:0] out_rate [NAVG];
  logic          out_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld_d_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_e     <= side_d_out.e;
      out_idx   <= side_d_out.idx;
      out_cfg   <= cfg_next;
      out_gc    <= gc_next;
      out_fault <= side_d_out.fault;
      for (int l = 0; l < NAVG; l++) begin
        out_rate[l] <= side_d_out.fault ? '0 : lanes_d_out[l].dq;
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_rate[4], out_rate[3], out_rate[2], out_rate[1],
                         out_rate[0], out_gc, out_cfg, out_idx, out_e};
  assign m_axis_tuser = out_fault;

  `ATCC_ASSERT_IMP(a_fallback_div, m_axis_tvalid && (max_adc_clock_hz == '0), out_e == FALLBACK_E, "fallback divider exponent not applied")
  `ATCC_ASSERT_IMP(a_fault_idx, m_axis_tvalid && out_fault, out_idx == '0, "adder index nonzero on zero ADC clock")
  `ATCC_ASSERT_IMP(a_rate_order, m_axis_tvalid, (out_rate[0] >= out_rate[1]) && (out_rate[3] >= out_rate[4]), "sample rates not falling with averaging depth")
  `ATCC_ASSERT_NEXT(a_max_write, cfg_wr && (reg_idx == REG_MAX_CLK), max_adc_clock_hz == $past(pwdata[DW-1:0]), "max ADC clock register write lost")

endmodule

[sim/adc_timing_config_calculator_checker.sv]
`timescale 1ns / 1ps

module adc_timing_config_calculator_checker
  import atcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [183:0] m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [4:0]    e;
    logic [2:0]    idx;
    logic [16:0]   cfg;
    logic [7:0]    gc;
    logic [4:0][29:0] rate;
    logic          fault;
  } timing_t;

  logic [29:0] max_clk, bus_w;
  logic [19:0] min_ns;
  logic [1:0]  res, clk_src, conv, ref_sel;
  logic        ovr;
  logic [2:0]  avg;
  timing_t     timing_q[$];

  function automatic int adder_len(input logic [2:0] i);
    int lens[8] = '{3, 5, 7, 9, 13, 17, 21, 25};
    return lens[i];
  endfunction

  function automatic timing_t compute_timing(input logic [29:0] bus);
    timing_t t;
    logic [63:0] q, adck, period, need;
    logic [4:0] e;
    int i, n;
    t = '0;
    if (max_clk != 0) begin
      q = 64'(bus) / 64'(max_clk) + 1;
      e = 5'd0;
      while (q != 0) begin
        e++;
        q >>= 1;
      end
    end else begin
      e = 5'd3;
    end
    adck = 64'(bus) >> e;
    t.e = e;
    t.fault = (adck == 0);
    if (!t.fault) begin
      period = 64'd1000000000 / adck;
      need = 64'(min_ns) / period;
      for (i = 0; i < 8; i++) begin
        if (64'(adder_len(3'(i))) > need) begin
          t.idx = 3'(i);
          break;
        end
      end
    end
    if (ref_sel == 1) t.cfg |= 17'h800;
    else if (ref_sel == 2) t.cfg |= 17'h1000;
    if (ovr) t.cfg |= 17'h10000;
    if (res == 1) t.cfg |= 17'h4;
    else if (res == 2) t.cfg |= 17'h8;
    if (e == 1) t.cfg |= 17'h20;
    else if (e == 2) t.cfg |= 17'h40;
    else if (e == 3) t.cfg |= 17'h60;
    else if (e == 4 && clk_src == 0) t.cfg |= 17'h61;
    t.cfg |= {7'h0, t.idx[1:0], 3'b0, t.idx[2], 4'h0};
    case (avg)
      3'd1: t.gc = 8'h20;
      3'd2: begin t.gc = 8'h20; t.cfg |= 17'h4000; end
      3'd3: begin t.gc = 8'h20; t.cfg |= 17'h8000; end
      3'd4: begin t.gc = 8'h20; t.cfg |= 17'hC000; end
      default: ;
    endcase
    if (conv == 2) t.cfg |= 17'h80;
    if (conv == 1) t.cfg |= 17'h400;
    for (i = 0; i < 5; i++) begin
      n = (i == 0) ? 1 : (2 << i);
      if (!t.fault)
        t.rate[i] = 30'(adck / (6 + 64'(n) * (25 + 64'(adder_len(t.idx)))));
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = timing_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    timing_t want, got;
    int i;
    if (rst) begin
      max_clk <= '0; min_ns <= 20'd1000; res <= 2'd2; clk_src <= 2'd0;
      conv <= 2'd2; ref_sel <= 2'd0; ovr <= 1'b1; avg <= 3'd1;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_MAX_CLK:  max_clk <= pwdata[29:0];
          REG_MIN_TIME: min_ns <= pwdata[19:0];
          REG_RES:      res <= pwdata[1:0];
          REG_CLK_SRC:  clk_src <= pwdata[1:0];
          REG_CONV:     conv <= pwdata[1:0];
          REG_REF:      ref_sel <= pwdata[1:0];
          REG_OVR:      ovr <= pwdata[0];
          REG_AVG:      avg <= pwdata[2:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bus_w = s_axis_tdata[29:0];
        timing_q.push_back(compute_timing(bus_w));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.e = m_axis_tdata[4:0];
        got.idx = m_axis_tdata[7:5];
        got.cfg = m_axis_tdata[24:8];
        got.gc = m_axis_tdata[32:25];
        for (i = 0; i < 5; i++) got.rate[i] = m_axis_tdata[33 + 30*i +: 30];
        got.fault = m_axis_tuser[0];
        if (timing_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = timing_q.pop_front();
          if (got.e != want.e) report_mismatch("divider_log2", got.e, want.e);
          if (got.idx != want.idx) report_mismatch("adder_index", got.idx, want.idx);
          if (got.cfg != want.cfg) report_mismatch("cfg_word", got.cfg, want.cfg);
          if (got.gc != want.gc) report_mismatch("gc_word", got.gc, want.gc);
          for (i = 0; i < 5; i++)
            if (got.rate[i] != want.rate[i])
              report_mismatch($sformatf("rate[%0d]", i), got.rate[i], want.rate[i]);
          if (got.fault != want.fault) report_mismatch("fault", got.fault, want.fault);
        end
      end
    end
  end

endmodule

[sim/adc_timing_config_calculator_tb.sv]
`timescale 1ns / 1ps

module adc_timing_config_calculator_tb;
  import atcc_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // [29:0] bus_clock_hz
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [183:0] m_axis_tdata;        // divider_log2, adder_index, cfg, gc, five rates
  logic [0:0]   m_axis_tuser;        // [0] fault
  int           fail_count, pending;
  int           send_idle = 0, recv_stall = 0;
  bit           hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  adc_timing_config_calculator u_top (.*);

  adc_timing_config_calculator_checker u_chk (.*);

  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
  endtask

  task automatic send_clock(input logic [29:0] bus);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, bus};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drain, then let the pipeline settle before touching registers.
  task automatic wait_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  function automatic logic [29:0] rand_bus();
    case ($urandom_range(3))
      0: return 30'($urandom_range(1000000000));
      1: return 30'($urandom_range(200));
      2: return 30'($urandom) & 30'h3FFFFFFF;
      default: return 30'($urandom_range(100000000, 1000));
    endcase
  endfunction

  task automatic write_all(input logic [29:0] mx, input logic [19:0] mn,
                           input logic [2:0] a);
    apb_write(REG_MAX_CLK, {2'b0, mx});
    apb_write(REG_MIN_TIME, {12'b0, mn});
    apb_write(REG_RES, $urandom_range(3));
    apb_write(REG_CLK_SRC, $urandom_range(3));
    apb_write(REG_CONV, $urandom_range(3));
    apb_write(REG_REF, $urandom_range(3));
    apb_write(REG_OVR, $urandom_range(1));
    apb_write(REG_AVG, {29'b0, a});
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  always @(posedge clk) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  initial begin
    #20ms;
    $display("adc_timing_config_calculator_tb NOT OK");
    $finish;
  end

  initial begin
    logic [29:0] corner[8];
    int ph;
    corner = '{30'd0, 30'd1, 30'd7, 30'd8, 30'd1000000000, 30'h3FFFFFFF,
               30'd16, 30'd100000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (corner[i]) send_clock(corner[i]);
    wait_idle();
    write_all(30'h3FFFFFFF, 20'hFFFFF, 3'd7);
    foreach (corner[i]) send_clock(corner[i]);
    wait_idle();
    write_all(30'd1, 20'd0, 3'd0);
    foreach (corner[i]) send_clock(corner[i]);
    wait_idle();
    write_all(30'd1000000000, 20'd1000000, 3'd4);
    send_clock(30'd1000000000);
    send_clock(30'd0);
    wait_idle();
    // Long hold on the result side while inputs keep coming.
    hold_off = 1;
    fork
      repeat (200) send_clock(rand_bus());
      repeat (400) @(posedge clk);
    join_any
    hold_off = 0;
    wait fork;
    wait_idle();
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 76; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 76; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      write_all($urandom_range(2) == 0 ? 30'd0 : 30'($urandom_range(200000000)),
                20'($urandom_range(1 << 20)), 3'($urandom_range(7)));
      repeat (48) send_clock(rand_bus());
      wait_idle();
    end
    if (fail_count == 0)
      $display("adc_timing_config_calculator_tb OK");
    else
      $display("adc_timing_config_calculator_tb NOT OK");
    $finish;
  end

endmodule

[adc_timing_config_calculator.f]
+incdir+rtl/core
rtl/core/atcc_pkg.sv
rtl/core/atcc_div_cell.sv
rtl/core/atcc_div_chain.sv
rtl/core/adc_timing_config_calculator.sv
sim/adc_timing_config_calculator_checker.sv
sim/adc_timing_config_calculator_tb.sv
